>>> sv/midi_track_time_signature_parser_unit_assert.svh
// Assertion macros for the time-signature parser.
`ifndef MIDI_TRACK_TIME_SIGNATURE_PARSER_UNIT_ASSERT_SVH
`define MIDI_TRACK_TIME_SIGNATURE_PARSER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define MTSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Property whose consequence must hold at the following clock edge.
`define MTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTSP_ASSERT_NOW(lbl, ante, cons, msg)
`define MTSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/mtsp_pkg.sv
// Types and constants shared by the time-signature parser modules.
package mtsp_pkg;

  localparam int TICK_BITS = 32;

  localparam logic [7:0] ST_META  = 8'hFF;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_ESC   = 8'hF7;
  localparam logic [7:0] META_EOT  = 8'h2F;
  localparam logic [7:0] META_TSIG = 8'h58;
  localparam logic [3:0] KIND_LOW  = 4'h8;
  localparam logic [3:0] KIND_HIGH = 4'hE;
  localparam logic [3:0] KIND_PROG  = 4'hC;
  localparam logic [3:0] KIND_PRESS = 4'hD;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_META_TYPE = 4'd2,
    PH_META_LEN  = 4'd3,
    PH_SIG_NUM   = 4'd4,
    PH_SIG_DEN   = 4'd5,
    PH_SYSEX_LEN = 4'd6,
    PH_SKIP      = 4'd7,
    PH_HALT      = 4'd8
  } phase_t;

  // One registered input byte on its way into the parser.
  typedef struct packed {
    logic       valid;
    logic       track_start;
    logic [7:0] data;
  } byte_t;

  // One decoded time signature.
  typedef struct packed {
    logic [7:0]  denom_power;
    logic [7:0]  numerator;
    logic [31:0] tick;
  } sig_t;

endpackage

>>> sv/midi_track_time_signature_parser_unit.sv
// Top level of the track time-signature parser.
//
// The input channel carries one byte of a track chunk body per transfer, with
// in_tuser marking the first byte of a new track. The parser decodes delta
// times into an absolute tick, follows running status, skips meta, sysex and
// channel data bytes, and emits one result transfer for each time-signature
// meta event with a length of at least two, carrying tick, numerator and the
// denominator exponent. End of track, a data byte without running status, or
// an undefined status halts parsing until the next track start.
// Throughput is one byte per cycle while no denominator byte is stalled. A
// byte is registered in the input register on acceptance and decoded from
// there; its result, if any, is registered in the output register. All
// decoding is a single pass of logic between the two registers.
// Reset clears the parser as if a track had just begun and empties both
// register stages. When the receiver stalls, the output register holds its
// result; bytes that produce no result keep flowing until the next
// denominator byte, which waits in the input register, and only then does
// in_tready drop.
module midi_track_time_signature_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] track_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] sig_tick, [39:32] sig_numerator,
                                  // [47:40] sig_denom_power
);
  import mtsp_pkg::*;

  byte_t byte_s;
  sig_t  sig_s;
  logic  advance;
  logic  emit;
  logic  out_free;

  // Input register: one byte waiting for the parser.
  mtsp_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_data       (in_tdata),
    .in_track_start(in_tuser[0]),
    .advance       (advance),
    .byte_o        (byte_s)
  );

  // Parser state and the decode of one byte.
  mtsp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_i  (byte_s),
    .out_free(out_free),
    .advance (advance),
    .emit    (emit),
    .sig_o   (sig_s)
  );

  // Output register: the result waits here for the receiver.
  mtsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .sig_i     (sig_s),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_free  (out_free)
  );

endmodule

>>> sv/mtsp_in_stage.sv
// Input register stage that holds one accepted byte until the parser takes it.
module mtsp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_data,
  input  logic           in_track_start,
  input  logic           advance,
  output mtsp_pkg::byte_t byte_o
);
  import mtsp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic       start_r;
  logic [7:0] data_r;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r  <= in_data;
      start_r <= in_track_start;
    end
  end

  assign byte_o = '{valid: valid_r, track_start: start_r, data: data_r};

endmodule

>>> sv/mtsp_parser.sv
// Track event parser: delta times, running status, skips and time signatures.
`include "midi_track_time_signature_parser_unit_assert.svh"
module mtsp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  mtsp_pkg::byte_t byte_i,
  input  logic            out_free,
  output logic            advance,
  output logic            emit,
  output mtsp_pkg::sig_t  sig_o
);
  import mtsp_pkg::*;

  phase_t                phase_r, phase_nxt, cur_phase;
  logic [31:0]           delta_r, delta_nxt, cur_delta;
  logic [TICK_BITS-1:0]  tick_r, tick_nxt, cur_tick;
  logic [7:0]            rs_r, rs_nxt, cur_rs;
  logic                  rv_r, rv_nxt, cur_rv;
  logic [7:0]            meta_r, meta_nxt, cur_meta;
  logic [31:0]           len_r, len_nxt, cur_len;
  logic [31:0]           skip_r, skip_nxt, cur_skip;
  logic [7:0]            num_r, num_nxt, cur_num;
  logic                  fire;
  logic [7:0]            b;
  logic [7:0]            status;
  logic                  used_running;
  logic [1:0]            need;
  logic [31:0]           delta_sh;
  logic [31:0]           len_sh;
  logic [31:0]           skip_n;
  logic [31:0]           skip_dec;

  // A byte that would produce a result waits until the output register is free.
  assign emit    = byte_i.valid && (cur_phase == PH_SIG_DEN);
  assign advance = !emit || out_free;
  assign fire    = byte_i.valid && advance;
  assign b       = byte_i.data;

  // A track start clears the parser before its byte is taken.
  always_comb begin
    if (byte_i.track_start) begin
      cur_phase = PH_DELTA;
      cur_delta = '0;
      cur_tick  = '0;
      cur_rs    = '0;
      cur_rv    = 1'b0;
      cur_meta  = '0;
      cur_len   = '0;
      cur_skip  = '0;
      cur_num   = '0;
    end else begin
      cur_phase = phase_r;
      cur_delta = delta_r;
      cur_tick  = tick_r;
      cur_rs    = rs_r;
      cur_rv    = rv_r;
      cur_meta  = meta_r;
      cur_len   = len_r;
      cur_skip  = skip_r;
      cur_num   = num_r;
    end
  end

  assign delta_sh = {cur_delta[24:0], b[6:0]};
  assign len_sh   = {cur_len[24:0], b[6:0]};
  assign status   = b[7] ? b : cur_rs;
  assign used_running = !b[7];
  assign skip_dec = (cur_skip != '0) ? cur_skip - 32'd1 : cur_skip;

  always_comb begin
    phase_nxt = cur_phase;
    delta_nxt = cur_delta;
    tick_nxt  = cur_tick;
    rs_nxt    = cur_rs;
    rv_nxt    = cur_rv;
    meta_nxt  = cur_meta;
    len_nxt   = cur_len;
    skip_nxt  = cur_skip;
    num_nxt   = cur_num;
    need      = 2'd0;
    skip_n    = '0;
    unique case (cur_phase)
      PH_DELTA: begin
        delta_nxt = delta_sh;
        if (!b[7]) begin
          tick_nxt  = cur_tick + TICK_BITS'(delta_sh);
          delta_nxt = '0;
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!b[7] && !cur_rv) begin
          phase_nxt = PH_HALT;
        end else begin
          if (status != ST_SYSEX && status != ST_ESC && status != ST_META) begin
            rs_nxt = status;
            rv_nxt = 1'b1;
          end
          if (status == ST_META) begin
            phase_nxt = PH_META_TYPE;
          end else if (status == ST_SYSEX || status == ST_ESC) begin
            len_nxt   = '0;
            phase_nxt = PH_SYSEX_LEN;
          end else if (status[7:4] == KIND_PROG || status[7:4] == KIND_PRESS) begin
            need = used_running ? 2'd0 : 2'd1;
            skip_nxt  = 32'(need);
            phase_nxt = (need == 2'd0) ? PH_DELTA : PH_SKIP;
          end else if (status[7:4] >= KIND_LOW && status[7:4] <= KIND_HIGH) begin
            need = used_running ? 2'd1 : 2'd2;
            skip_nxt  = 32'(need);
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_HALT;
          end
        end
      end
      PH_META_TYPE: begin
        meta_nxt  = b;
        len_nxt   = '0;
        phase_nxt = PH_META_LEN;
      end
      PH_META_LEN: begin
        len_nxt = len_sh;
        if (!b[7]) begin
          if (cur_meta == META_EOT) begin
            phase_nxt = PH_HALT;
          end else if (cur_meta == META_TSIG && len_sh >= 32'd2) begin
            skip_nxt  = len_sh;
            phase_nxt = PH_SIG_NUM;
          end else begin
            skip_nxt  = len_sh;
            phase_nxt = (len_sh == '0) ? PH_DELTA : PH_SKIP;
          end
        end
      end
      PH_SIG_NUM: begin
        num_nxt   = b;
        phase_nxt = PH_SIG_DEN;
      end
      PH_SIG_DEN: begin
        skip_n    = cur_skip - 32'd2;
        skip_nxt  = skip_n;
        phase_nxt = (skip_n == '0) ? PH_DELTA : PH_SKIP;
      end
      PH_SYSEX_LEN: begin
        len_nxt = len_sh;
        if (!b[7]) begin
          skip_nxt  = len_sh;
          phase_nxt = (len_sh == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_DELTA;
        end
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      delta_r <= '0;
      tick_r  <= '0;
      rs_r    <= '0;
      rv_r    <= 1'b0;
      meta_r  <= '0;
      len_r   <= '0;
      skip_r  <= '0;
      num_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      delta_r <= delta_nxt;
      tick_r  <= tick_nxt;
      rs_r    <= rs_nxt;
      rv_r    <= rv_nxt;
      meta_r  <= meta_nxt;
      len_r   <= len_nxt;
      skip_r  <= skip_nxt;
      num_r   <= num_nxt;
    end
  end

  assign sig_o = '{denom_power: b, numerator: cur_num, tick: 32'(cur_tick)};

  `MTSP_ASSERT_NOW(a_skip_nonzero, phase_r == PH_SKIP, skip_r != '0,
    "skip phase with nothing left to skip")
  `MTSP_ASSERT_NOW(a_stall_only_on_result, byte_i.valid && !advance,
    phase_r == PH_SIG_DEN && !byte_i.track_start, "parser stalled without a result")
  `MTSP_ASSERT_NEXT(a_halt_sticky, phase_r == PH_HALT && !(byte_i.valid && byte_i.track_start),
    phase_r == PH_HALT, "parser left halt without a track start")
  `MTSP_ASSERT_NEXT(a_num_then_den,
    fire && !byte_i.track_start && phase_r == PH_SIG_NUM, phase_r == PH_SIG_DEN,
    "numerator not followed by denominator")

endmodule

>>> sv/mtsp_out_stage.sv
// Output register that holds one time-signature result until it is taken.
module mtsp_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  mtsp_pkg::sig_t sig_i,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [47:0]    out_tdata,
  output logic           out_free
);
  import mtsp_pkg::*;

  logic valid_r;
  logic valid_nxt;
  sig_t sig_r;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      sig_r <= sig_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {sig_r.denom_power, sig_r.numerator, sig_r.tick};

endmodule

>>> dv/tb.sv
// Self-checking testbench for the track time-signature parser.
`timescale 1ns / 100ps

module tb;
  import mtsp_pkg::*;

  localparam int STUCK_LIMIT = 2000;  // cycles without any transfer
  localparam int HOLD_CYCLES = 240;   // long receiver hold-off
  localparam int ITEM_GOAL   = 750;   // parsed bytes in the random part
  localparam int QUIET_FROM  = 630;   // no idling from here on

  // One row of the directed part. When has_sig is set, the result that the
  // byte causes is written out in the row instead of being predicted.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       has_sig;
    sig_t       want;
  } intro_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [0:0]  in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  midi_track_time_signature_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Predicted parser state, advanced once per accepted input transfer.
  phase_t               trk_phase;
  logic [31:0]          trk_delta;
  logic [TICK_BITS-1:0] trk_tick;
  logic [7:0]           trk_run_st;
  logic                 trk_run_ok;
  logic [7:0]           trk_meta;
  logic [31:0]          trk_len;
  logic [31:0]          trk_skip;
  logic [7:0]           trk_num;

  sig_t       sig_fifo[$];      // time signatures still owed by the block
  intro_row_t intro_rows[$];
  int         mismatches = 0;
  int         parsed_items = 0;
  int         stuck_cycles = 0;
  bit         quiet = 1'b0;     // set near the end: no idling on either side
  bit         gappy = 1'b1;     // sender inserts gaps in the current track
  bit         rx_calm = 1'b0;
  bit         hold_req = 1'b0;
  logic       next_start = 1'b0;

  function automatic void clear_track();
    trk_phase  = PH_DELTA;
    trk_delta  = '0;
    trk_tick   = '0;
    trk_run_st = '0;
    trk_run_ok = 1'b0;
    trk_meta   = '0;
    trk_len    = '0;
    trk_skip   = '0;
    trk_num    = '0;
  endfunction

  function automatic void skip_then_delta(input logic [31:0] n);
    trk_skip = n;
    if (n == 32'd0) trk_phase = PH_DELTA;
    else trk_phase = PH_SKIP;
  endfunction

  // Advances the predicted parser by one byte. Returns 1 when the byte
  // completes a time signature, which is then handed back in sig.
  function automatic bit time_sig_after_byte(input logic [7:0] b, input logic start,
                                             output sig_t sig);
    logic [7:0] st;
    logic [3:0] kind;
    bit         via_running;
    sig = '0;
    time_sig_after_byte = 1'b0;
    if (start) clear_track();
    unique case (trk_phase)
      PH_DELTA: begin
        trk_delta = {trk_delta[24:0], b[6:0]};
        if (!b[7]) begin
          trk_tick  = trk_tick + TICK_BITS'(trk_delta);
          trk_delta = '0;
          trk_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!b[7] && !trk_run_ok) begin
          trk_phase = PH_HALT;
        end else begin
          // A data byte here reuses the last channel status and is itself
          // the first data byte of the message.
          via_running = !b[7];
          st = b[7] ? b : trk_run_st;
          if (st != ST_SYSEX && st != ST_ESC && st != ST_META) begin
            trk_run_st = st;
            trk_run_ok = 1'b1;
          end
          kind = st[7:4];
          if (st == ST_META) begin
            trk_phase = PH_META_TYPE;
          end else if (st == ST_SYSEX || st == ST_ESC) begin
            trk_len   = '0;
            trk_phase = PH_SYSEX_LEN;
          end else if (kind == KIND_PROG || kind == KIND_PRESS) begin
            skip_then_delta(via_running ? 32'd0 : 32'd1);
          end else if (kind >= KIND_LOW && kind <= KIND_HIGH) begin
            skip_then_delta(via_running ? 32'd1 : 32'd2);
          end else begin
            trk_phase = PH_HALT;
          end
        end
      end
      PH_META_TYPE: begin
        trk_meta  = b;
        trk_len   = '0;
        trk_phase = PH_META_LEN;
      end
      PH_META_LEN: begin
        trk_len = {trk_len[24:0], b[6:0]};
        if (!b[7]) begin
          if (trk_meta == META_EOT) begin
            trk_phase = PH_HALT;
          end else if (trk_meta == META_TSIG && trk_len >= 32'd2) begin
            trk_skip  = trk_len;
            trk_phase = PH_SIG_NUM;
          end else begin
            skip_then_delta(trk_len);
          end
        end
      end
      PH_SIG_NUM: begin
        trk_num   = b;
        trk_phase = PH_SIG_DEN;
      end
      PH_SIG_DEN: begin
        sig.tick        = 32'(trk_tick);
        sig.numerator   = trk_num;
        sig.denom_power = b;
        time_sig_after_byte = 1'b1;
        skip_then_delta(trk_skip - 32'd2);
      end
      PH_SYSEX_LEN: begin
        trk_len = {trk_len[24:0], b[6:0]};
        if (!b[7]) skip_then_delta(trk_len);
      end
      PH_SKIP: begin
        if (trk_skip != 32'd0) trk_skip = trk_skip - 32'd1;
        if (trk_skip == 32'd0) trk_phase = PH_DELTA;
      end
      default: trk_phase = PH_HALT;
    endcase
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic s);
    intro_row_t row;
    row = '{data: d, start: s, has_sig: 1'b0, want: '0};
    intro_rows.insert(intro_rows.size(), row);
  endfunction

  function automatic void add_sig_row(input logic [7:0] d, input logic [31:0] tick,
                                      input logic [7:0] num, input logic [7:0] den);
    intro_row_t row;
    row = '{data: d, start: 1'b0, has_sig: 1'b1,
            want: '{denom_power: den, numerator: num, tick: tick}};
    intro_rows.insert(intro_rows.size(), row);
  endfunction

  // Offers one byte, waits for its transfer and records what it should cause.
  // Bytes that a halted parser ignores are not counted.
  task automatic send_byte(input logic [7:0] d, input logic s, input logic has_sig,
                           input sig_t want);
    sig_t sig;
    bit   made;
    if (!quiet && gappy && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (s || trk_phase != PH_HALT) parsed_items++;
    made = time_sig_after_byte(d, s, sig);
    if (has_sig) sig_fifo.insert(sig_fifo.size(), want);
    else if (made) sig_fifo.insert(sig_fifo.size(), sig);
  endtask

  task automatic put_byte(input logic [7:0] d);
    send_byte(d, next_start, 1'b0, '0);
    next_start = 1'b0;
  endtask

  // Delta times are mostly one byte; a few run to five bytes so that the
  // absolute tick wraps and the top bits of the value fall away.
  task automatic put_delta();
    int r;
    int nb;
    r = $urandom_range(0, 9);
    if (r < 6) nb = 1;
    else if (r < 9) nb = $urandom_range(2, 3);
    else nb = $urandom_range(4, 5);
    repeat (nb - 1) put_byte(8'h80 | 8'($urandom_range(0, 127)));
    put_byte(8'($urandom_range(0, 127)));
  endtask

  // Length and body of a meta or sysex event. Now and then the length takes
  // two bytes, which also yields long bodies.
  task automatic put_payload(input int max_len);
    int len;
    int hi;
    int lo;
    if ($urandom_range(0, 15) == 0) begin
      hi  = $urandom_range(0, 1);
      lo  = $urandom_range(0, 3);
      len = hi * 128 + lo;
      put_byte(8'h80 | 8'(hi));
      put_byte(8'(lo));
    end else begin
      len = $urandom_range(0, max_len);
      put_byte(8'(len));
    end
    repeat (len) put_byte(8'($urandom_range(0, 255)));
  endtask

  // One track: a start byte, a run of well-formed events with random
  // content and a little noise, then end of track, an undefined status,
  // or nothing at all so that the next track start cuts it short.
  task automatic play_track();
    int         pick;
    logic [7:0] st;
    logic [7:0] last_chan;
    bit         running;
    last_chan  = 8'h00;
    next_start = 1'b1;
    gappy      = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(1, 10)) begin
      put_delta();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        put_byte(ST_META);
        put_byte(META_TSIG);
        put_payload(6);
      end else if (pick < 50) begin
        put_byte(ST_META);
        st = 8'($urandom_range(0, 127));
        if (st == META_EOT || st == META_TSIG) st = 8'h01;
        put_byte(st);
        put_payload(5);
      end else if (pick < 60) begin
        put_byte($urandom_range(0, 1) ? ST_SYSEX : ST_ESC);
        put_payload(5);
      end else if (pick < 96) begin
        running = (last_chan != 8'h00) && ($urandom_range(0, 2) == 0);
        st = last_chan;
        if (!running) begin
          st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
          last_chan = st;
          put_byte(st);
        end
        repeat ((st[7:4] == KIND_PROG || st[7:4] == KIND_PRESS) ? 1 : 2)
          put_byte(8'($urandom_range(0, 127)));
      end else begin
        put_byte(8'($urandom_range(0, 255)));
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      put_delta();
      put_byte(ST_META);
      put_byte(META_EOT);
      put_byte(8'h00);
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
    end else if (pick < 8) begin
      put_delta();
      st = 8'($urandom_range(241, 254));
      if (st == ST_ESC) st = 8'hF8;
      put_byte(st);
    end
  endtask

  // Result channel: random stalls, calm stretches, and one long hold-off
  // that lets the block fill up and push back on its input.
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
    end
  end

  // Every result transfer is matched against the oldest owed time signature.
  always @(posedge clk) begin
    sig_t got;
    sig_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sig_t'(out_tdata);
      if (sig_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tick %h num %h den %h",
                   got.tick, got.numerator, got.denom_power);
      end else begin
        want = sig_fifo.pop_front();
        if (got.tick !== want.tick || got.numerator !== want.numerator ||
            got.denom_power !== want.denom_power) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected tick %h num %h den %h, got tick %h num %h den %h",
                     want.tick, want.numerator, want.denom_power,
                     got.tick, got.numerator, got.denom_power);
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    bit hold_asked;
    bit pause_done;
    hold_asked = 1'b0;
    pause_done = 1'b0;
    clear_track();

    // The first track is parsed without a start marker, as after reset.
    add_row(8'h00, 1'b0);
    // Time signature with two extra payload bytes that are skipped.
    add_row(8'hFF, 1'b0); add_row(8'h58, 1'b0); add_row(8'h04, 1'b0);
    add_row(8'h04, 1'b0); add_sig_row(8'h02, 32'd0, 8'h04, 8'h02);
    add_row(8'h18, 1'b0); add_row(8'h08, 1'b0);
    // Two-byte delta of 128, then a time signature of length zero.
    add_row(8'h81, 1'b0); add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0); add_row(8'h58, 1'b0); add_row(8'h00, 1'b0);
    // Shortest full time signature with all-ones payload.
    add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0); add_row(8'h58, 1'b0);
    add_row(8'h02, 1'b0); add_row(8'hFF, 1'b0);
    add_sig_row(8'hFF, 32'd128, 8'hFF, 8'hFF);
    // End of track, then a byte the halted parser ignores.
    add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0); add_row(8'h2F, 1'b0);
    add_row(8'h00, 1'b0); add_row(8'h55, 1'b0);
    // New track: a data byte with no running status halts it.
    add_row(8'h00, 1'b1); add_row(8'h40, 1'b0);
    // New track: an undefined system status halts it.
    add_row(8'h00, 1'b1); add_row(8'hF4, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (intro_rows[i])
      send_byte(intro_rows[i].data, intro_rows[i].start, intro_rows[i].has_sig,
                intro_rows[i].want);
    parsed_items = 0;

    while (parsed_items < ITEM_GOAL) begin
      if (!hold_asked && parsed_items >= 150) begin
        hold_asked = 1'b1;
        hold_req   = 1'b1;
      end
      if (!pause_done && parsed_items >= 400) begin
        // Let the block drain completely before the next track.
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sig_fifo.size() != 0) @(posedge clk);
      end
      quiet = (parsed_items >= QUIET_FROM);
      play_track();
    end
    in_tvalid <= 1'b0;

    while (sig_fifo.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
